// ----- hw/rtl/catmull_rom_segment_sampler_core_defines.svh -----
// Assertion macros shared by the sampler RTL; the asserting module must have clk and rst_n.
`ifndef CATMULL_ROM_SEGMENT_SAMPLER_CORE_DEFINES_SVH
`define CATMULL_ROM_SEGMENT_SAMPLER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crss: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CRSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crss: next-cycle check failed");

`endif

// ----- hw/rtl/crss_pkg.sv -----
// Shared types, constants, tables and arithmetic helpers of the segment sampler.
`default_nettype none

package crss_pkg;

    // Samples per segment and width of the sample index
    localparam int SAMPLES   = 30;
    localparam int SAMPLES_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    // Horner pipeline depth (three multiply stages, three round/add stages)
    localparam int HORNER_DEPTH = 6;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_TENSION = 1'b0;
    localparam logic [15:0] TENSION_RESET = 16'd2048;

    // Data types
    typedef logic signed [31:0] sample_t;   // Q16.16 coordinate
    typedef logic signed [35:0] dot_t;      // basis row dot product
    typedef logic signed [52:0] cprod_t;    // dot product times tension
    typedef logic signed [40:0] coef_t;     // cubic coefficient, Q16.16
    typedef logic signed [57:0] hprod_t;    // Horner accumulator times t
    typedef logic [15:0]        tq_t;       // t in Q0.16
    typedef logic [15:0]        tension_t;  // Q4.12

    typedef sample_t quad_t [4];
    typedef logic signed [3:0] basis_t [4][4];
    typedef tq_t tq_table_t [SAMPLES];

    // Catmull-Rom basis, unscaled
    localparam basis_t BASIS = '{
        '{-4'sd1,  4'sd3, -4'sd3,  4'sd1},
        '{ 4'sd2, -4'sd5,  4'sd4, -4'sd1},
        '{-4'sd1,  4'sd0,  4'sd1,  4'sd0},
        '{ 4'sd0,  4'sd2,  4'sd0,  4'sd0}
    };

    // t = round(j / SAMPLES) in Q0.16, built at elaboration
    function automatic tq_table_t build_tq_table();
        tq_table_t t;
        for (int j = 0; j < SAMPLES; j++) begin
            t[j] = tq_t'((j * 65536 + SAMPLES / 2) / SAMPLES);
        end
        return t;
    endfunction

    localparam tq_table_t TQ_TABLE = build_tq_table();

    // Controller to datapath commands
    typedef struct packed {
        logic                 load_dot;
        logic                 load_prod;
        logic                 load_coef;
        logic                 issue;
        logic                 first;
        logic                 last;
        logic [SAMPLES_W-1:0] idx;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic adv;
    } dp_status_t;

    // Dot product of one basis row with four coordinates (small constant weights)
    function automatic dot_t dot_row(input logic [1:0] k, input quad_t p);
        dot_t acc;
        acc = '0;
        for (int i = 0; i < 4; i++) begin
            acc = acc + dot_t'(BASIS[k][i]) * dot_t'(p[i]);
        end
        return acc;
    endfunction

    // Round half up of p / 2^12
    function automatic coef_t rnd12(input cprod_t p);
        cprod_t tmp;
        tmp = p + cprod_t'(2048);
        return coef_t'(tmp >>> 12);
    endfunction

    // Round half up of m / 2^16
    function automatic coef_t rnd16(input hprod_t m);
        hprod_t tmp;
        tmp = m + hprod_t'(32768);
        return coef_t'(tmp >>> 16);
    endfunction

    // Clamp to the signed 32-bit range
    function automatic sample_t sat32(input coef_t v);
        sample_t r;
        if (v[40:31] == '0 || v[40:31] == '1) begin
            r = v[31:0];
        end else if (v[40]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/catmull_rom_segment_sampler_core.sv -----
// Top level of the Catmull-Rom segment sampler: config register, sequencer and datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one segment per transfer: four control
//   points p0..p3 (x, y in signed Q16.16) and new_curve, which restarts the monotonic
//   filter before this segment.
//   Output channel (out_valid / out_stall) returns 30 samples per segment at t = j/30,
//   one transfer each, with kept (x above the last kept x) and last_sample on j = 29.
//   Path: the first sample of a segment passes the dot-product, tension-product and
//   coefficient registers, six Horner stages and the output register to out_valid.
//   Segments are taken one at a time: after the setup steps the sample issue counter
//   steps through the samples, and the input is freed once the last one is issued.
//   in_stall is high from the cycle after a transfer until the last sample is issued.
//   When out_stall holds a sample, the whole sample pipeline and the issue counter freeze.
//   Reset clears the sequencer, the pipeline valids and the filter; tension returns to
//   0.5 (2048). The APB port (pready always high) holds tension at address 0; write it
//   only while no segment is in flight.
`default_nettype none

module catmull_rom_segment_sampler_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // APB configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [crss_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [crss_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [crss_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    // Segment input
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire crss_pkg::sample_t               p0_x,
    input  wire crss_pkg::sample_t               p0_y,
    input  wire crss_pkg::sample_t               p1_x,
    input  wire crss_pkg::sample_t               p1_y,
    input  wire crss_pkg::sample_t               p2_x,
    input  wire crss_pkg::sample_t               p2_y,
    input  wire crss_pkg::sample_t               p3_x,
    input  wire crss_pkg::sample_t               p3_y,
    input  wire logic                            new_curve,
    // Sample output
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output crss_pkg::sample_t                    sample_x,
    output crss_pkg::sample_t                    sample_y,
    output logic                                 kept,
    output logic                                 last_sample
);
    import crss_pkg::*;

    tension_t             tension_reg, tension_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    quad_t                px, py;
    ctrl_cmd_t            cmd;
    dp_status_t           status;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        tension_next = tension_reg;
        prdata       = '0;
        unique case (reg_idx)
            REG_TENSION:
            begin
                prdata = APB_DATA_W'(tension_reg);
                if (wr_en)
                begin
                    tension_next = pwdata[15:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= TENSION_RESET;
        end
        else
        begin
            tension_reg <= tension_next;
        end
    end

    // Control point bundles
    assign px[0] = p0_x;
    assign px[1] = p1_x;
    assign px[2] = p2_x;
    assign px[3] = p3_x;
    assign py[0] = p0_y;
    assign py[1] = p1_y;
    assign py[2] = p2_y;
    assign py[3] = p3_y;

    crss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    crss_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .tension     (tension_reg),
        .px          (px),
        .py          (py),
        .new_curve   (new_curve),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .kept        (kept),
        .last_sample (last_sample)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/crss_horner.sv -----
// One-axis Horner evaluation pipeline: three multiply and three round/add stages.
`default_nettype none

module crss_horner (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire crss_pkg::coef_t coef_a,
    input  wire crss_pkg::coef_t coef_b,
    input  wire crss_pkg::coef_t coef_c,
    input  wire crss_pkg::coef_t coef_d,
    input  wire crss_pkg::tq_t   tq,
    output crss_pkg::sample_t    result
);
    import crss_pkg::*;

    hprod_t  m1_reg, m3_reg, m5_reg;
    hprod_t  m1_next, m3_next, m5_next;
    coef_t   s2_reg, s4_reg;
    coef_t   s2_next, s4_next;
    sample_t s6_reg, s6_next;
    coef_t   b1_reg, c1_reg, d1_reg;
    coef_t   c2_reg, d2_reg;
    coef_t   c3_reg, d3_reg;
    coef_t   d4_reg, d5_reg;
    tq_t     tq1_reg, tq2_reg, tq3_reg, tq4_reg;

    // Stage arithmetic; t is unsigned so it gets a zero sign bit
    always_comb
    begin
        m1_next = hprod_t'(coef_a) * hprod_t'($signed({1'b0, tq}));
        s2_next = rnd16(m1_reg) + b1_reg;
        m3_next = hprod_t'(s2_reg) * hprod_t'($signed({1'b0, tq2_reg}));
        s4_next = rnd16(m3_reg) + c3_reg;
        m5_next = hprod_t'(s4_reg) * hprod_t'($signed({1'b0, tq4_reg}));
        s6_next = sat32(rnd16(m5_reg) + d5_reg);
    end

    // Pipeline registers, coefficients travel with each sample
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= m1_next;
            b1_reg  <= coef_b;
            c1_reg  <= coef_c;
            d1_reg  <= coef_d;
            tq1_reg <= tq;

            s2_reg  <= s2_next;
            c2_reg  <= c1_reg;
            d2_reg  <= d1_reg;
            tq2_reg <= tq1_reg;

            m3_reg  <= m3_next;
            c3_reg  <= c2_reg;
            d3_reg  <= d2_reg;
            tq3_reg <= tq2_reg;

            s4_reg  <= s4_next;
            d4_reg  <= d3_reg;
            tq4_reg <= tq3_reg;

            m5_reg  <= m5_next;
            d5_reg  <= d4_reg;

            s6_reg  <= s6_next;
        end
    end

    assign result = s6_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/crss_ctrl.sv -----
// Sequencer: accepts a segment, steps coefficient setup, then issues the samples.
`default_nettype none

module crss_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire crss_pkg::dp_status_t status,
    output crss_pkg::ctrl_cmd_t       cmd
);
    import crss_pkg::*;

    `include "catmull_rom_segment_sampler_core_defines.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_ISSUE
    } state_t;

    localparam logic [SAMPLES_W-1:0] J_LAST = SAMPLES_W'(SAMPLES - 1);

    state_t               state_reg, state_next;
    logic                 stall_reg, stall_next;
    logic [SAMPLES_W-1:0] j_reg, j_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        stall_next = stall_reg;
        j_next     = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                    stall_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_RND;
            end
            ST_RND:
            begin
                state_next = ST_ISSUE;
                j_next     = '0;
            end
            ST_ISSUE:
            begin
                if (status.adv)
                begin
                    if (j_reg == J_LAST)
                    begin
                        state_next = ST_IDLE;
                        stall_next = 1'b0;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                stall_next = 1'b0;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
            j_reg     <= j_next;
        end
    end

    assign in_stall = stall_reg;

    // Datapath commands
    always_comb
    begin
        cmd.load_dot  = (state_reg == ST_IDLE) && in_valid;
        cmd.load_prod = (state_reg == ST_MUL);
        cmd.load_coef = (state_reg == ST_RND);
        cmd.issue     = (state_reg == ST_ISSUE) && status.adv;
        cmd.first     = (j_reg == '0);
        cmd.last      = (j_reg == J_LAST);
        cmd.idx       = j_reg;
    end

    // Checks
    `CRSS_ASSERT_NEXT(a_accept_then_busy, in_valid && !stall_reg, stall_reg)
    `CRSS_ASSERT_NEXT(a_final_issue_frees, cmd.issue && cmd.last, !stall_reg)
    `CRSS_ASSERT_NOW(a_index_in_range, state_reg == ST_ISSUE, j_reg <= J_LAST)

endmodule

`default_nettype wire

// ----- hw/rtl/crss_dp.sv -----
// Datapath: coefficient setup, two Horner pipelines, monotonic filter and output register.
`default_nettype none

module crss_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire crss_pkg::ctrl_cmd_t cmd,
    output crss_pkg::dp_status_t     status,
    input  wire crss_pkg::tension_t  tension,
    input  wire crss_pkg::quad_t     px,
    input  wire crss_pkg::quad_t     py,
    input  wire logic                new_curve,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output crss_pkg::sample_t        sample_x,
    output crss_pkg::sample_t        sample_y,
    output logic                     kept,
    output logic                     last_sample
);
    import crss_pkg::*;

    `include "catmull_rom_segment_sampler_core_defines.svh"

    typedef struct packed {
        logic valid;
        logic last;
        logic newc;
    } side_t;

    dot_t    dot_x_reg  [4];
    dot_t    dot_y_reg  [4];
    cprod_t  prod_x_reg [4];
    cprod_t  prod_y_reg [4];
    coef_t   coef_x_reg [4];
    coef_t   coef_y_reg [4];
    logic    newc_reg;

    side_t   side_reg [HORNER_DEPTH];
    side_t   side_in;
    side_t   side_out;
    logic    adv;
    tq_t     tq;
    sample_t hx, hy;

    logic    out_valid_reg;
    sample_t sample_x_reg, sample_y_reg;
    logic    kept_reg, last_reg;
    logic    any_kept_reg, any_kept_next;
    sample_t last_kept_x_reg, last_kept_x_next;
    logic    keep;

    // Whole sample pipeline moves when the output register can take a transfer
    assign adv        = !out_valid_reg || !out_stall;
    assign status.adv = adv;

    // Coefficient setup: dot product, tension product, rounding
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (cmd.load_dot)
            begin
                dot_x_reg[k] <= dot_row(2'(k), px);
                dot_y_reg[k] <= dot_row(2'(k), py);
            end
            if (cmd.load_prod)
            begin
                prod_x_reg[k] <= cprod_t'(dot_x_reg[k]) * cprod_t'($signed({1'b0, tension}));
                prod_y_reg[k] <= cprod_t'(dot_y_reg[k]) * cprod_t'($signed({1'b0, tension}));
            end
            if (cmd.load_coef)
            begin
                coef_x_reg[k] <= rnd12(prod_x_reg[k]);
                coef_y_reg[k] <= rnd12(prod_y_reg[k]);
            end
        end
        if (cmd.load_dot)
        begin
            newc_reg <= new_curve;
        end
    end

    // Sample parameter lookup
    assign tq = TQ_TABLE[cmd.idx];

    crss_horner u_horner_x (
        .clk    (clk),
        .en     (adv),
        .coef_a (coef_x_reg[0]),
        .coef_b (coef_x_reg[1]),
        .coef_c (coef_x_reg[2]),
        .coef_d (coef_x_reg[3]),
        .tq     (tq),
        .result (hx)
    );

    crss_horner u_horner_y (
        .clk    (clk),
        .en     (adv),
        .coef_a (coef_y_reg[0]),
        .coef_b (coef_y_reg[1]),
        .coef_c (coef_y_reg[2]),
        .coef_d (coef_y_reg[3]),
        .tq     (tq),
        .result (hy)
    );

    // Valid and sideband line alongside the Horner stages
    always_comb
    begin
        side_in.valid = cmd.issue;
        side_in.last  = cmd.last;
        side_in.newc  = cmd.first && newc_reg;
        side_out      = side_reg[HORNER_DEPTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HORNER_DEPTH; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < HORNER_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Monotonic filter; a new curve forces a keep and restarts the running x
    always_comb
    begin
        keep             = side_out.newc || !any_kept_reg || (hx > last_kept_x_reg);
        any_kept_next    = any_kept_reg;
        last_kept_x_next = last_kept_x_reg;
        if (adv && side_out.valid && keep)
        begin
            any_kept_next    = 1'b1;
            last_kept_x_next = hx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            any_kept_reg    <= 1'b0;
            last_kept_x_reg <= '0;
        end
        else
        begin
            any_kept_reg    <= any_kept_next;
            last_kept_x_reg <= last_kept_x_next;
            if (adv)
            begin
                out_valid_reg <= side_out.valid;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (adv && side_out.valid)
        begin
            sample_x_reg <= hx;
            sample_y_reg <= hy;
            kept_reg     <= keep;
            last_reg     <= side_out.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_x    = sample_x_reg;
    assign sample_y    = sample_y_reg;
    assign kept        = kept_reg;
    assign last_sample = last_reg;

    // Checks
    `CRSS_ASSERT_NEXT(a_new_curve_kept, adv && side_out.valid && side_out.newc, out_valid_reg && kept_reg)
    `CRSS_ASSERT_NEXT(a_sample_lands, adv && side_out.valid, out_valid_reg)
    `CRSS_ASSERT_NOW(a_issue_only_moving, cmd.issue, adv)

endmodule

`default_nettype wire

// ----- tb/catmull_rom_segment_sampler_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the Catmull-Rom segment sampler: directed table, random curves.

module catmull_rom_segment_sampler_core_tb;
    import crss_pkg::*;

    localparam int NSAMP = crss_pkg::SAMPLES;
    localparam logic [APB_ADDR_W-1:0] TENSION_ADDR = APB_ADDR_W'(4 * REG_TENSION);
    // one word past the register list, writes there must be ignored
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR   = APB_ADDR_W'(4);
    localparam sample_t S_MAX = 32'sh7fff_ffff;
    localparam sample_t S_MIN = 32'sh8000_0000;
    localparam sample_t ONE   = 32'sh0001_0000;
    localparam int N_DIRECTED  = 17;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 19;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [3:0][31:0] px;
        logic [3:0][31:0] py;
        logic             nc;
    } segment_t;

    typedef struct packed {
        tension_t ten;
        segment_t seg;
        logic     typed;
        sample_t  exp_x;
        sample_t  exp_y;
    } dir_row_t;

    typedef struct packed {
        sample_t x;
        sample_t y;
        logic    kept;
        logic    last;
    } sample_rec_t;

    // DUT connections
    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    sample_t               p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    logic                  new_curve;
    logic                  out_valid;
    logic                  out_stall;
    sample_t               sample_x;
    sample_t               sample_y;
    logic                  kept;
    logic                  last_sample;

    // Predictor state: tension copy and monotonic filter
    tension_t    cur_tension;
    longint      filt_last_x;
    bit          filt_any;
    sample_rec_t expected_samples[$];

    int       mismatches;
    bit       idle_on;
    int       out_gap;
    dir_row_t directed[N_DIRECTED];

    // Sliding window of the current well-formed curve
    sample_t win_x[4];
    sample_t win_y[4];
    int      curve_left;

    catmull_rom_segment_sampler_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .p0_x        (p0_x),
        .p0_y        (p0_y),
        .p1_x        (p1_x),
        .p1_y        (p1_y),
        .p2_x        (p2_x),
        .p2_y        (p2_y),
        .p3_x        (p3_x),
        .p3_y        (p3_y),
        .new_curve   (new_curve),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .kept        (kept),
        .last_sample (last_sample)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endtask

    // Round half up of v / 2^s
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Tension-scaled cubic coefficients of one axis, Q16.16
    function automatic void axis_coeffs(input logic [3:0][31:0] p, input tension_t ten,
                                        output longint c[4]);
        longint q[4];
        longint dot[4];
        for (int i = 0; i < 4; i++)
        begin
            q[i] = longint'(sample_t'(p[i]));
        end
        dot[0] = -q[0] + 3 * q[1] - 3 * q[2] + q[3];
        dot[1] = 2 * q[0] - 5 * q[1] + 4 * q[2] - q[3];
        dot[2] = -q[0] + q[2];
        dot[3] = 2 * q[1];
        for (int k = 0; k < 4; k++)
        begin
            c[k] = round_half_up(dot[k] * longint'(ten), 12);
        end
    endfunction

    // Horner evaluation at tq (Q0.16), saturated to 32 bits
    function automatic longint eval_cubic(input longint c[4], input longint tq);
        longint acc;
        acc = c[0];
        for (int k = 1; k < 4; k++)
        begin
            acc = round_half_up(acc * tq, 16) + c[k];
        end
        if (acc > longint'(S_MAX))
        begin
            acc = longint'(S_MAX);
        end
        else if (acc < longint'(S_MIN))
        begin
            acc = longint'(S_MIN);
        end
        return acc;
    endfunction

    // Append one expected sample to the scoreboard
    function automatic void enqueue_sample(input sample_rec_t r);
        expected_samples.insert(expected_samples.size(), r);
    endfunction

    // Expected samples of one segment; updates the filter
    function automatic void sample_segment(input segment_t s);
        longint      cx[4];
        longint      cy[4];
        longint      tq;
        longint      x;
        longint      y;
        bit          keep;
        sample_rec_t r;
        if (s.nc)
        begin
            filt_any    = 1'b0;
            filt_last_x = 0;
        end
        axis_coeffs(s.px, cur_tension, cx);
        axis_coeffs(s.py, cur_tension, cy);
        for (int j = 0; j < NSAMP; j++)
        begin
            tq   = (longint'(j) * 65536 + NSAMP / 2) / NSAMP;
            x    = eval_cubic(cx, tq);
            y    = eval_cubic(cy, tq);
            keep = !filt_any || (x > filt_last_x);
            if (keep)
            begin
                filt_last_x = x;
                filt_any    = 1'b1;
            end
            r.x    = sample_t'(x);
            r.y    = sample_t'(y);
            r.kept = keep;
            r.last = (j == NSAMP - 1);
            enqueue_sample(r);
        end
    endfunction

    // Constant-result row that starts a curve: first sample kept, the rest equal
    function automatic void push_constant_row(input dir_row_t row);
        sample_rec_t r;
        filt_any    = 1'b1;
        filt_last_x = longint'(row.exp_x);
        for (int j = 0; j < NSAMP; j++)
        begin
            r.x    = row.exp_x;
            r.y    = row.exp_y;
            r.kept = (j == 0);
            r.last = (j == NSAMP - 1);
            enqueue_sample(r);
        end
    endfunction

    function automatic dir_row_t make_row(input tension_t ten,
                                          input sample_t x0, x1, x2, x3,
                                          input sample_t y0, y1, y2, y3,
                                          input logic nc, input logic typed,
                                          input sample_t ex, input sample_t ey);
        dir_row_t row;
        row.ten        = ten;
        row.seg.px     = {x3, x2, x1, x0};
        row.seg.py     = {y3, y2, y1, y0};
        row.seg.nc     = nc;
        row.typed      = typed;
        row.exp_x      = ex;
        row.exp_y      = ey;
        return row;
    endfunction

    // Random segment: mostly sliding-window curves, some noise, extremes and backward runs
    function automatic segment_t next_random_segment();
        segment_t s;
        int       kind;
        sample_t  step;
        sample_t  pick[5];
        kind    = $urandom_range(0, 9);
        pick    = '{S_MAX, S_MIN, 32'sd0, -32'sd1, ONE};
        s.nc    = 1'b0;
        if (kind <= 6)
        begin
            if (curve_left == 0)
            begin
                curve_left = $urandom_range(1, 6);
                win_x[0]   = sample_t'($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
                for (int i = 0; i < 4; i++)
                begin
                    if (i > 0)
                    begin
                        step     = sample_t'($urandom_range(0, 32'h0044_0000)) - 32'sh0004_0000;
                        win_x[i] = win_x[i-1] + step;
                    end
                    win_y[i] = sample_t'($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
                end
                s.nc = 1'b1;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_x[i] = win_x[i+1];
                    win_y[i] = win_y[i+1];
                end
                step     = sample_t'($urandom_range(0, 32'h0044_0000)) - 32'sh0004_0000;
                win_x[3] = win_x[2] + step;
                win_y[3] = sample_t'($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            end
            curve_left--;
            for (int i = 0; i < 4; i++)
            begin
                s.px[i] = win_x[i];
                s.py[i] = win_y[i];
            end
        end
        else if (kind == 7)
        begin
            // full-range noise
            for (int i = 0; i < 4; i++)
            begin
                s.px[i] = $urandom;
                s.py[i] = $urandom;
            end
            s.nc = 1'($urandom_range(0, 1));
        end
        else if (kind == 8)
        begin
            // extreme coordinates
            for (int i = 0; i < 4; i++)
            begin
                s.px[i] = pick[$urandom_range(0, 4)];
                s.py[i] = pick[$urandom_range(0, 4)];
            end
            s.nc = 1'($urandom_range(0, 1));
        end
        else
        begin
            // x running backward inside a curve
            s.px[0] = sample_t'($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            for (int i = 1; i < 4; i++)
            begin
                s.px[i] = sample_t'(s.px[i-1]) - sample_t'($urandom_range(0, 32'h0040_0000));
            end
            for (int i = 0; i < 4; i++)
            begin
                s.py[i] = sample_t'($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            end
        end
        return s;
    endfunction

    // One input transfer, after a random gap when idling is on
    task automatic transfer_segment(input segment_t s);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        p0_x      = s.px[0];
        p0_y      = s.py[0];
        p1_x      = s.px[1];
        p1_y      = s.py[1];
        p2_x      = s.px[2];
        p2_y      = s.py[2];
        p3_x      = s.px[3];
        p3_y      = s.py[3];
        new_curve = s.nc;
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Hold the sender until every expected sample has come
    task automatic drain_samples();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Read tension back and compare with the predictor's copy
    task automatic check_tension_reg();
        logic [31:0] rd;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = TENSION_ADDR;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== {16'h0000, cur_tension})
        begin
            report_mismatch($sformatf("tension read: expected %0d, got %0d", cur_tension, rd));
        end
    endtask

    task automatic set_tension(input tension_t v);
        apb_write(TENSION_ADDR, {16'h0000, v});
        cur_tension = v;
        check_tension_reg();
    endtask

    // Output check at each sample transfer
    always @(posedge clk)
    begin : check_samples
        sample_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch($sformatf("unexpected sample x=%0d y=%0d kept=%0b last=%0b",
                                          sample_x, sample_y, kept, last_sample));
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample_x !== want.x || sample_y !== want.y ||
                    kept !== want.kept || last_sample !== want.last)
                begin
                    report_mismatch($sformatf(
                        "sample: expected x=%0d y=%0d kept=%0b last=%0b, got x=%0d y=%0d %s",
                        want.x, want.y, want.kept, want.last, sample_x, sample_y,
                        $sformatf("kept=%0b last=%0b", kept, last_sample)));
                end
            end
            out_gap = idle_on ? $urandom_range(0, 7) : 0;
        end
    end

    // Receiver stall
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_stall = 1'b1;
            out_gap   = out_gap - 1;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        segment_t seg;
        tension_t ten;
        clk         = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        p0_x        = '0;
        p0_y        = '0;
        p1_x        = '0;
        p1_y        = '0;
        p2_x        = '0;
        p2_y        = '0;
        p3_x        = '0;
        p3_y        = '0;
        new_curve   = 1'b0;
        out_stall   = 1'b0;
        out_gap     = 0;
        mismatches  = 0;
        idle_on     = 1'b1;
        curve_left  = 0;
        cur_tension = TENSION_RESET;
        filt_last_x = 0;
        filt_any    = 1'b0;

        // Directed table; typed rows have constant, obvious results
        directed[0]  = make_row(TENSION_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 0, 0);
        directed[1]  = make_row(TENSION_RESET, ONE, ONE, ONE, ONE,
                                -2 * ONE, -2 * ONE, -2 * ONE, -2 * ONE, 1'b1, 1'b1,
                                ONE, -2 * ONE);
        directed[2]  = make_row(TENSION_RESET, S_MAX, S_MAX, S_MAX, S_MAX,
                                S_MAX, S_MAX, S_MAX, S_MAX, 1'b1, 1'b1, S_MAX, S_MAX);
        directed[3]  = make_row(TENSION_RESET, S_MIN, S_MIN, S_MIN, S_MIN,
                                S_MIN, S_MIN, S_MIN, S_MIN, 1'b1, 1'b1, S_MIN, S_MIN);
        directed[4]  = make_row(16'hffff, S_MAX, S_MAX, S_MAX, S_MAX,
                                S_MIN, S_MIN, S_MIN, S_MIN, 1'b1, 1'b1, S_MAX, S_MIN);
        directed[5]  = make_row(16'hffff, S_MIN, S_MIN, S_MIN, S_MIN,
                                S_MAX, S_MAX, S_MAX, S_MAX, 1'b1, 1'b1, S_MIN, S_MAX);
        // zero tension gives the origin everywhere
        directed[6]  = make_row(16'h0000, 32'sh1234_5678, -32'sh0765_4321, 32'sh0abc_def0, 5,
                                -7, 32'sh7654_3210, -32'sh1111_1111, 32'sh0000_ffff,
                                1'b1, 1'b1, 0, 0);
        directed[7]  = make_row(16'h0000, S_MAX, S_MIN, S_MAX, S_MIN,
                                S_MIN, S_MAX, S_MIN, S_MAX, 1'b1, 1'b1, 0, 0);
        directed[8]  = make_row(TENSION_RESET, S_MAX, S_MIN, S_MAX, S_MIN,
                                S_MIN, S_MAX, S_MIN, S_MAX, 1'b1, 1'b0, 0, 0);
        directed[9]  = make_row(TENSION_RESET, 0, ONE, 2 * ONE, 3 * ONE,
                                0, ONE, 0, -ONE, 1'b1, 1'b0, 0, 0);
        directed[10] = make_row(TENSION_RESET, ONE, 2 * ONE, 3 * ONE, 4 * ONE,
                                ONE, 0, -ONE, 0, 1'b0, 1'b0, 0, 0);
        // x running back: only the first sample kept without a restart
        directed[11] = make_row(TENSION_RESET, 4 * ONE, 3 * ONE, 2 * ONE, ONE,
                                0, 0, 0, 0, 1'b0, 1'b0, 0, 0);
        directed[12] = make_row(TENSION_RESET, 4 * ONE, 3 * ONE, 2 * ONE, ONE,
                                0, ONE, 2 * ONE, 3 * ONE, 1'b1, 1'b0, 0, 0);
        directed[13] = make_row(16'h1000, 0, ONE, 3 * ONE, 4 * ONE,
                                0, 2 * ONE, -2 * ONE, 0, 1'b1, 1'b0, 0, 0);
        directed[14] = make_row(16'h0001, -1, 32'sh0fff_ffff, -32'sh0fff_ffff, 1,
                                32'sh4000_0000, -32'sh4000_0000, 3, -3, 1'b0, 1'b0, 0, 0);
        directed[15] = make_row(16'h8000, 32'sh0123_4567, 32'sh0234_5678, 32'sh0345_6789,
                                32'sh0456_789a, -ONE, ONE, -ONE, ONE, 1'b1, 1'b0, 0, 0);
        directed[16] = make_row(16'hffff, S_MAX, S_MIN, S_MAX, S_MIN,
                                S_MAX, S_MAX, S_MIN, S_MIN, 1'b0, 1'b0, 0, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        check_tension_reg();

        // Directed part
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed[i].ten != cur_tension)
            begin
                drain_samples();
                set_tension(directed[i].ten);
            end
            transfer_segment(directed[i].seg);
            if (directed[i].typed)
            begin
                push_constant_row(directed[i]);
            end
            else
            begin
                sample_segment(directed[i].seg);
            end
        end

        // Write past the register list: tension must stay
        drain_samples();
        apb_write(SPARE_ADDR, 32'h0000_0123);
        check_tension_reg();

        // Random phases: every phase but the first sets its tension; idling is chosen per phase
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain_samples();
                case (ph)
                    1:       ten = 16'hffff;
                    3:       ten = TENSION_RESET;
                    4:       ten = 16'h1000;
                    default: ten = tension_t'($urandom);
                endcase
                set_tension(ten);
            end
            idle_on = (ph == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    drain_samples();
                end
                seg = next_random_segment();
                transfer_segment(seg);
                sample_segment(seg);
            end
        end

        // Wind down and watch for stray samples
        drain_samples();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
